FILE: sv/slet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the scanline lane edge tracker.
// No dependencies; imported by every other file of the block.
package slet_pkg;

  localparam int unsigned FRAME_WIDTH = 640;
  localparam logic [7:0]  EDGE_VALUE  = 8'd255;

  localparam int unsigned CFG_NUM = 3;
  localparam int unsigned CFG_IW  = 2;

  localparam logic [CFG_IW-1:0] CFG_CENTER    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DEAD_ZONE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TOLERANCE = 2'd2;

  typedef struct packed {
    logic [9:0] center_column;
    logic [9:0] dead_zone;
    logic [9:0] tol_limit;
  } cfg_t;

  // One finished scanline as handed from the front to the back.
  typedef struct packed {
    logic       up_found;
    logic [9:0] up_x;
    logic       dn_found;
    logic [9:0] dn_x;
    logic [8:0] row_y;
    logic       frame_end;
  } rec_t;

  typedef struct packed {
    logic       side;
    logic [9:0] bottom_x;
    logic [8:0] bottom_y;
    logic [9:0] top_x;
    logic [8:0] top_y;
    logic       line_valid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       stopped;
    logic       prev_ok;
    logic       bot_seen;
    logic       line_ok;
    logic [9:0] prev_x;
    logic [9:0] bot_x;
    logic [8:0] bot_y;
    logic [9:0] top_x;
    logic [8:0] top_y;
  } side_t;

endpackage

FILE: sv/slet_front.sv
`timescale 1ns / 1ps
// Front part: accepts pixels, finds the upward and downward edge of each scanline
// and pushes one record per finished scanline. Depends on slet_pkg.
module slet_front
  import slet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel,
  input  logic [9:0] in_column,
  input  logic [8:0] in_row_y,
  input  logic       in_row_end,
  input  logic       in_frame_end,
  input  logic       q_full,
  output logic       q_push,
  output rec_t       q_rec
);

  logic       up_seen_r, up_seen_nxt;
  logic [9:0] up_x_r, up_x_nxt;
  logic       dn_seen_r, dn_seen_nxt;
  logic [9:0] dn_x_r, dn_x_nxt;
  logic       accept;
  logic       is_edge;
  logic       up_hit;
  logic       dn_hit;
  logic       line_done;
  logic [10:0] right_sum;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_edge   = (in_pixel == EDGE_VALUE);
  assign right_sum = {1'b0, in_column} + {1'b0, cfg.dead_zone};
  assign up_hit    = is_edge && !up_seen_r && (in_column >= cfg.center_column)
                     && (right_sum < 11'(FRAME_WIDTH));
  assign dn_hit    = is_edge && (in_column > cfg.dead_zone)
                     && (in_column <= cfg.center_column);
  assign line_done = in_row_end || in_frame_end;

  always_comb begin
    up_seen_nxt = up_seen_r || up_hit;
    up_x_nxt    = up_hit ? in_column : up_x_r;
    dn_seen_nxt = dn_seen_r || dn_hit;
    dn_x_nxt    = dn_hit ? in_column : dn_x_r;
  end

  assign q_push          = accept && line_done;
  assign q_rec.up_found  = up_seen_nxt;
  assign q_rec.up_x      = up_x_nxt;
  assign q_rec.dn_found  = dn_seen_nxt;
  assign q_rec.dn_x      = dn_x_nxt;
  assign q_rec.row_y     = in_row_y;
  assign q_rec.frame_end = in_frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_seen_r <= 1'b0;
      up_x_r    <= '0;
      dn_seen_r <= 1'b0;
      dn_x_r    <= '0;
    end else if (accept) begin
      if (line_done) begin
        up_seen_r <= 1'b0;
        up_x_r    <= '0;
        dn_seen_r <= 1'b0;
        dn_x_r    <= '0;
      end else begin
        up_seen_r <= up_seen_nxt;
        up_x_r    <= up_x_nxt;
        dn_seen_r <= dn_seen_nxt;
        dn_x_r    <= dn_x_nxt;
      end
    end
  end

endmodule

FILE: sv/slet_fifo.sv
`timescale 1ns / 1ps
// Short register queue of scanline records between the front and the back.
// Depends on slet_pkg.
module slet_fifo
  import slet_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t din,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output rec_t dout
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rec_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: sv/slet_back.sv
`timescale 1ns / 1ps
// Back part: runs the two line trackers on each scanline record and, at frame end,
// delivers the two results through an output register. Depends on slet_pkg.
module slet_back
  import slet_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_not_empty,
  input  rec_t q_rec,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  function automatic side_t track(side_t s, logic found, logic [9:0] x, logic [8:0] y,
                                  logic [9:0] tol);
    side_t      n;
    logic [9:0] d;
    n = s;
    d = (s.prev_x > x) ? (s.prev_x - x) : (x - s.prev_x);
    if (!s.stopped) begin
      if (!found) begin
        n.prev_ok = 1'b0;
      end else if (!s.bot_seen) begin
        n.bot_x    = x;
        n.bot_y    = y;
        n.bot_seen = 1'b1;
        n.prev_x   = x;
        n.prev_ok  = 1'b1;
      end else if (!s.prev_ok) begin
        n.stopped = 1'b1;
      end else if (d < tol) begin
        n.top_x   = x;
        n.top_y   = y;
        n.line_ok = 1'b1;
        n.prev_x  = x;
        n.prev_ok = 1'b1;
      end else begin
        n.stopped = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic res_t make_res(side_t s, logic sd);
    res_t r;
    r.side       = sd;
    r.bottom_x   = s.bot_x;
    r.bottom_y   = s.bot_y;
    r.top_x      = s.top_x;
    r.top_y      = s.top_y;
    r.line_valid = s.line_ok;
    r.last       = sd;
    return r;
  endfunction

  side_t side0_r, side0_nxt;
  side_t side1_r, side1_nxt;
  res_t  out_res_r;
  res_t  second_r;
  logic  out_valid_r;
  logic  second_pend_r;
  logic  slot_free;

  assign slot_free = (!out_valid_r || out_ready) && !second_pend_r;
  assign q_pop     = q_not_empty && (!q_rec.frame_end || slot_free);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    side0_nxt = track(side0_r, q_rec.up_found, q_rec.up_x, q_rec.row_y, cfg.tol_limit);
    side1_nxt = track(side1_r, q_rec.dn_found, q_rec.dn_x, q_rec.row_y, cfg.tol_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side0_r       <= '0;
      side1_r       <= '0;
      out_valid_r   <= 1'b0;
      second_pend_r <= 1'b0;
    end else begin
      if (q_pop && q_rec.frame_end) begin
        out_valid_r   <= 1'b1;
        second_pend_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r   <= second_pend_r;
        second_pend_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_rec.frame_end) begin
          side0_r <= '0;
          side1_r <= '0;
        end else begin
          side0_r <= side0_nxt;
          side1_r <= side1_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_ready && second_pend_r) begin
      out_res_r <= second_r;
    end
    if (q_pop && q_rec.frame_end) begin
      out_res_r <= make_res(side0_nxt, 1'b0);
      second_r  <= make_res(side1_nxt, 1'b1);
    end
  end

endmodule

FILE: sv/scanline_lane_edge_tracker_core.sv
`timescale 1ns / 1ps
// Top level of the scanline lane edge tracker: configuration registers, front,
// record queue and back. Depends on slet_pkg, slet_front, slet_fifo and slet_back.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    pixel, column, row_y, row_end, frame_end
//   out_     output     out_valid / out_ready  side, bottom/top points, line_valid, last
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one pixel per cycle while the queue is not full; a finished
// scanline costs one queue entry. The back retires one scanline record per cycle,
// but holds a frame-end record until the output register is free; a frame end yields
// two results through the output register, and the queue absorbs that gap. The
// frame-end record passes the queue and then the out_valid register to the output.
// Reset clears control state at once, not queue or result data; no clearing pass.
// in_ready drops only while the queue is full; cfg_ready is always high.
module scanline_lane_edge_tracker_core
  import slet_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_pixel,
  input  logic [9:0]        in_column,
  input  logic [8:0]        in_row_y,
  input  logic              in_row_end,
  input  logic              in_frame_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_side,
  output logic [9:0]        out_bottom_x,
  output logic [8:0]        out_bottom_y,
  output logic [9:0]        out_top_x,
  output logic [8:0]        out_top_y,
  output logic              out_line_valid,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [9:0]        cfg_data
);

  cfg_t cfg_r;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  rec_t q_in;
  rec_t q_out;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_column <= 10'd320;
      cfg_r.dead_zone     <= 10'd20;
      cfg_r.tol_limit     <= 10'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER:    cfg_r.center_column <= cfg_data;
        CFG_DEAD_ZONE: cfg_r.dead_zone     <= cfg_data;
        CFG_TOLERANCE: cfg_r.tol_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  slet_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .in_column    (in_column),
    .in_row_y     (in_row_y),
    .in_row_end   (in_row_end),
    .in_frame_end (in_frame_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (q_in)
  );

  slet_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_out)
  );

  slet_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_rec       (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res)
  );

  assign out_side       = res.side;
  assign out_bottom_x   = res.bottom_x;
  assign out_bottom_y   = res.bottom_y;
  assign out_top_x      = res.top_x;
  assign out_top_y      = res.top_y;
  assign out_line_valid = res.line_valid;
  assign out_last       = res.last;

  // The second result of a frame follows its first transaction at once.
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last && out_side)
    else $error("second result of a frame did not follow");

  a_no_top_without_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_valid |-> out_top_x == '0 && out_top_y == '0)
    else $error("top point reported without a valid line");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
